@@ hdl/gtl_pkg.sv @@
// Shared types, constants and helper functions for the Gherkin token lexer.
package gtl_pkg;

  localparam int POS_W   = 32;
  localparam int LINE_W  = 24;
  localparam int NKW     = 10;
  localparam int MAX_TOK = 3;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [NKW-1:0]    kwset_t;

  localparam pos_t  POS_MAX  = {POS_W{1'b1}};
  localparam line_t LINE_MAX = {LINE_W{1'b1}};

  localparam logic [4:0] K_NEWLINE  = 5'd0;
  localparam logic [4:0] K_TAG      = 5'd1;
  localparam logic [4:0] K_COLON    = 5'd2;
  localparam logic [4:0] K_PIPE     = 5'd3;
  localparam logic [4:0] K_LANGLE   = 5'd4;
  localparam logic [4:0] K_RANGLE   = 5'd5;
  localparam logic [4:0] K_LITERAL  = 5'd6;
  localparam logic [4:0] K_KEYWORD0 = 5'd7;
  localparam logic [4:0] K_SCENARIO = 5'd9;
  localparam logic [4:0] K_OUTLINE  = 5'd10;
  localparam logic [4:0] K_END      = 5'd17;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;

  // keyword text right-justified: char i sits at byte (len-1-i)
  localparam logic [127:0] KW_TEXT [NKW] = '{
    "Feature", "Background", "Scenario", "ScenarioOutline", "Examples",
    "Given", "When", "Then", "And", "But"};
  localparam logic [3:0] KW_LEN [NKW] = '{4'd7, 4'd10, 4'd8, 4'd15, 4'd8,
                                           4'd5, 4'd4, 4'd4, 4'd3, 4'd3};
  localparam logic [63:0] OUTLINE_TAIL = " Outline";

  localparam logic [3:0] REG_FIRST_LINE = 4'd0;

  typedef struct packed {
    logic [4:0]  kind;
    line_t       line;
    logic [31:0] start;
    logic [31:0] len;
  } tok_t;

  typedef struct packed {
    logic [1:0]           cnt;
    tok_t [MAX_TOK-1:0]   tok;
  } bundle_t;

  typedef struct packed {
    logic  we;
    line_t data;
  } cfg_wr_t;

  function automatic pos_t sat1(pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic pos_t sat9(pos_t v);
    return (v > POS_MAX - pos_t'(9)) ? POS_MAX : v + pos_t'(9);
  endfunction

  function automatic logic [7:0] kw_char(int k, logic [3:0] i);
    logic [3:0] j;
    j = KW_LEN[k] - 4'd1 - i;
    return KW_TEXT[k][{j, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] tail_char(logic [2:0] i);
    logic [2:0] j;
    j = 3'd7 - i;
    return OUTLINE_TAIL[{j, 3'b000} +: 8];
  endfunction

  function automatic kwset_t narrow(kwset_t cand, pos_t idx, logic [7:0] b);
    kwset_t r;
    r = '0;
    for (int k = 0; k < NKW; k++) begin
      if (cand[k] && idx < pos_t'(KW_LEN[k]) && kw_char(k, idx[3:0]) == b) begin
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] lit_kind(kwset_t cand, pos_t len);
    logic [4:0] r;
    r = K_LITERAL;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (cand[k] && len == pos_t'(KW_LEN[k])) begin
        r = K_KEYWORD0 + 5'(k);
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/gtl_front.sv @@
// Front end: lexer state, byte classification and token bundle building.
module gtl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       char_code,
  input  logic             end_of_source,
  input  gtl_pkg::cfg_wr_t cfg_wr,
  output gtl_pkg::line_t   first_line,
  output logic             push,
  output gtl_pkg::bundle_t bundle
);
  import gtl_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_TAG, M_LIT, M_OUT} mode_t;

  mode_t      mode_r, mode_nxt;
  kwset_t     cand_r, cand_nxt;
  pos_t       tl_r, tl_nxt;
  pos_t       ts_r, ts_nxt;
  pos_t       bp_r, bp_nxt;
  line_t      line_r, line_nxt;
  line_t      first_r;
  logic [3:0] omc_r, omc_nxt;
  pos_t       pss_r, pss_nxt;

  bundle_t    bun;
  logic [1:0] n;
  logic       do_fresh, do_lit, delim;
  pos_t       l_ts, l_tl;
  kwset_t     l_cand;
  logic [4:0] lk;

  function automatic tok_t mk(logic [4:0] k, line_t ln, pos_t s, pos_t l);
    tok_t t;
    t.kind  = k;
    t.line  = ln;
    t.start = s[31:0];
    t.len   = l[31:0];
    return t;
  endfunction

  always_comb begin
    mode_nxt = mode_r; cand_nxt = cand_r; tl_nxt = tl_r; ts_nxt = ts_r;
    bp_nxt = bp_r; line_nxt = line_r; omc_nxt = omc_r; pss_nxt = pss_r;
    bun = '0; n = 2'd0;
    do_fresh = 1'b0; do_lit = 1'b0;
    l_ts = ts_r; l_tl = tl_r; l_cand = cand_r;
    lk = K_LITERAL;
    delim = (char_code inside {[8'd9:8'd13], CH_SPACE, CH_LANGLE, CH_RANGLE, CH_COLON});
    if (end_of_source) begin
      case (mode_r)
        M_TAG: begin
          bun.tok[n] = mk(K_TAG, line_r, ts_r, tl_r); n = n + 2'd1;
        end
        M_LIT: begin
          bun.tok[n] = mk(lit_kind(cand_r, tl_r), line_r, ts_r, tl_r); n = n + 2'd1;
        end
        M_OUT: begin
          bun.tok[n] = mk(K_SCENARIO, line_r, pss_r, pos_t'(8)); n = n + 2'd1;
          if (omc_r >= 4'd2) begin
            bun.tok[n] = mk(K_LITERAL, line_r, sat9(pss_r), pos_t'(omc_r - 4'd1));
            n = n + 2'd1;
          end
        end
        default: ;
      endcase
      bun.tok[n] = mk(K_END, line_r, bp_r, '0); n = n + 2'd1;
      mode_nxt = M_IDLE; cand_nxt = '0; tl_nxt = '0; ts_nxt = '0; bp_nxt = '0;
      line_nxt = first_r; omc_nxt = '0; pss_nxt = '0;
    end else begin
      bp_nxt = sat1(bp_r);
      case (mode_r)
        M_TAG: begin
          if (char_code inside {[8'd9:8'd13], CH_SPACE}) begin
            bun.tok[n] = mk(K_TAG, line_r, ts_r, tl_r); n = n + 2'd1;
            do_fresh = 1'b1;
          end else begin
            tl_nxt = sat1(tl_r);
          end
        end
        M_LIT: do_lit = 1'b1;
        M_OUT: begin
          if (omc_r >= 4'd8) begin
            bun.tok[n] = mk(K_OUTLINE, line_r, pss_r, pos_t'(16)); n = n + 2'd1;
            omc_nxt = '0;
            do_fresh = 1'b1;
          end else if (tail_char(omc_r[2:0]) == char_code) begin
            omc_nxt = omc_r + 4'd1;
          end else begin
            // outline mismatch: emit Scenario, re-lex the consumed tail bytes
            bun.tok[n] = mk(K_SCENARIO, line_r, pss_r, pos_t'(8)); n = n + 2'd1;
            omc_nxt = '0;
            mode_nxt = M_IDLE;
            if (omc_r >= 4'd2) begin
              l_ts = sat9(pss_r); l_tl = pos_t'(omc_r - 4'd1); l_cand = '0;
              do_lit = 1'b1;
            end else begin
              do_fresh = 1'b1;
            end
          end
        end
        default: do_fresh = 1'b1;
      endcase
      if (do_lit) begin
        lk = lit_kind(l_cand, l_tl);
        if (!delim) begin
          mode_nxt = M_LIT; ts_nxt = l_ts;
          cand_nxt = narrow(l_cand, l_tl, char_code);
          tl_nxt = sat1(l_tl);
        end else if (lk == K_SCENARIO && char_code == CH_SPACE) begin
          mode_nxt = M_OUT; omc_nxt = 4'd1; pss_nxt = l_ts;
        end else begin
          bun.tok[n] = mk(lk, line_r, l_ts, l_tl); n = n + 2'd1;
          do_fresh = 1'b1;
        end
      end
      if (do_fresh) begin
        mode_nxt = M_IDLE;
        case (char_code)
          CH_NL: begin
            bun.tok[n] = mk(K_NEWLINE, line_r, bp_r, pos_t'(1)); n = n + 2'd1;
            if (line_r != LINE_MAX) line_nxt = line_r + line_t'(1);
          end
          CH_AT: begin
            mode_nxt = M_TAG; ts_nxt = bp_r; tl_nxt = pos_t'(1);
          end
          CH_COLON: begin
            bun.tok[n] = mk(K_COLON, line_r, bp_r, pos_t'(1)); n = n + 2'd1;
          end
          CH_PIPE: begin
            bun.tok[n] = mk(K_PIPE, line_r, bp_r, pos_t'(1)); n = n + 2'd1;
          end
          CH_LANGLE: begin
            bun.tok[n] = mk(K_LANGLE, line_r, bp_r, pos_t'(1)); n = n + 2'd1;
          end
          CH_RANGLE: begin
            bun.tok[n] = mk(K_RANGLE, line_r, bp_r, pos_t'(1)); n = n + 2'd1;
          end
          default: begin
            if (!(char_code inside {[8'd9:8'd13], CH_SPACE})) begin
              mode_nxt = M_LIT; ts_nxt = bp_r; tl_nxt = pos_t'(1);
              cand_nxt = narrow({NKW{1'b1}}, '0, char_code);
            end
          end
        endcase
      end
    end
    bun.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; cand_r <= '0; tl_r <= '0; ts_r <= '0; bp_r <= '0;
      line_r <= line_t'(1); first_r <= line_t'(1); omc_r <= '0; pss_r <= '0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt; cand_r <= cand_nxt; tl_r <= tl_nxt; ts_r <= ts_nxt;
        bp_r <= bp_nxt; line_r <= line_nxt; omc_r <= omc_nxt; pss_r <= pss_nxt;
      end
      if (cfg_wr.we) begin
        first_r <= cfg_wr.data;
        if (bp_r == '0) line_r <= cfg_wr.data;
      end
    end
  end

  assign push       = acc && (bun.cnt != 2'd0);
  assign bundle     = bun;
  assign first_line = first_r;

endmodule

@@ hdl/gtl_back.sv @@
// Back end: two-entry bundle queue and token serializer.
module gtl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gtl_pkg::bundle_t bundle,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output gtl_pkg::tok_t    out_tok,
  output logic             out_last
);
  import gtl_pkg::*;

  bundle_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, idx_r;
  logic       pop;
  bundle_t    head;

  assign head      = q_r[rp_r];
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_tok   = head.tok[idx_r];
  assign out_last  = (idx_r == head.cnt - 2'd1);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0; idx_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
      if (out_valid && out_ready) idx_r <= out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

@@ hdl/gherkin_token_lexer_unit.sv @@
// Top level of the Gherkin token lexer: APB register, front end and back end.
//
//  channel | ports                         | direction
//  input   | in_char_code, in_end_of_source | request in, valid/ready
//  result  | out_token_kind .. last_of_run  | request out, valid/ready
//  config  | cfg_p*                         | APB, first_line at 0x0
//
// One byte is taken per cycle while in_ready is high; in_ready drops only when
// the queue is full. A byte becomes a token bundle in the cycle it is taken.
// Tokens leave one per cycle while out_ready is high; the two-entry bundle queue
// lets input continue while a bundle drains. Reset is synchronous.
module gherkin_token_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [23:0] out_line_number,
  output logic [31:0] out_start_offset,
  output logic [31:0] out_lexeme_length,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gtl_pkg::*;

  cfg_wr_t cfg_wr;
  line_t   first_line;
  logic    acc, push, full;
  bundle_t bundle;
  tok_t    tok;

  assign cfg_pready = 1'b1;
  assign cfg_wr.we  = cfg_psel && cfg_penable && cfg_pwrite &&
                      ({1'b0, cfg_paddr[2]} == REG_FIRST_LINE[1:0]);
  assign cfg_wr.data = cfg_pwdata[LINE_W-1:0];
  assign cfg_prdata = ({1'b0, cfg_paddr[2]} == REG_FIRST_LINE[1:0]) ?
                      {{(32-LINE_W){1'b0}}, first_line} : 32'd0;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  gtl_front u_front (
    .clk, .rst_n, .acc,
    .char_code(in_char_code), .end_of_source(in_end_of_source),
    .cfg_wr, .first_line, .push, .bundle
  );

  gtl_back u_back (
    .clk, .rst_n, .push, .bundle, .full,
    .out_valid, .out_ready, .out_tok(tok), .out_last(out_last_of_run)
  );

  assign out_token_kind    = tok.kind;
  assign out_line_number   = tok.line;
  assign out_start_offset  = tok.start;
  assign out_lexeme_length = tok.len;

`ifndef SYNTH
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_kind <= K_END)) else $error("bad token kind");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_END |-> out_last_of_run)
    else $error("end token not last");
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_NEWLINE |-> out_last_of_run)
    else $error("newline token not last");
  a_eos_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_source |=> out_valid)
    else $error("end of source lost");
`endif

endmodule

@@ test/tb_gherkin_token_lexer_unit.sv @@
// Testbench for gherkin_token_lexer_unit: token predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_gherkin_token_lexer_unit;
  import gtl_pkg::*;

  typedef enum int {MD_IDLE, MD_TAG, MD_LIT, MD_OUT} lex_state_t;

  typedef struct {
    logic [4:0]  kind;
    logic [23:0] line;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_rec_t;

  class token_scoreboard;
    token_rec_t       tokens_due[$];
    token_rec_t       run[$];
    int               errors;
    lex_state_t       mode;
    logic [9:0]       cand;
    longint unsigned  tlen, tstart, bpos, scen_start;
    logic [23:0]      lcount, fline;
    int               omatch;
    string            kw_words[10];
    string            tail;

    function void clear_state();
      mode = MD_IDLE; cand = '0; tlen = 0; tstart = 0; bpos = 0;
      lcount = fline; omatch = 0; scen_start = 0;
    endfunction

    function void init();
      kw_words = '{"Feature", "Background", "Scenario", "ScenarioOutline", "Examples",
                   "Given", "When", "Then", "And", "But"};
      tail = " Outline";
      fline = 24'd1;
      errors = 0;
      clear_state();
    endfunction

    function longint unsigned sat(longint unsigned v, longint unsigned k);
      longint unsigned lim;
      lim = 64'hFFFF_FFFF;
      return (v >= lim || lim - v < k) ? lim : v + k;
    endfunction

    function bit is_space(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function void emit(logic [4:0] kind, longint unsigned st, longint unsigned ln);
      token_rec_t t;
      if (run.size() >= 3) return;
      t.kind = kind; t.line = lcount; t.start = st[31:0]; t.len = ln[31:0]; t.last = 0;
      run = {run, t};
    endfunction

    function logic [9:0] match_kw(logic [9:0] c, longint unsigned idx, logic [7:0] b);
      logic [9:0] r;
      r = '0;
      for (int k = 0; k < 10; k++)
        if (c[k] && idx < kw_words[k].len() && kw_words[k][idx] == b) r[k] = 1'b1;
      return r;
    endfunction

    function logic [4:0] word_kind();
      for (int k = 0; k < 10; k++)
        if (cand[k] && tlen == kw_words[k].len()) return K_KEYWORD0 + 5'(k);
      return K_LITERAL;
    endfunction

    function void start_byte(logic [7:0] b, longint unsigned pos);
      mode = MD_IDLE;
      if (b == CH_NL) begin
        emit(K_NEWLINE, pos, 1);
        if (lcount != LINE_MAX) lcount++;
      end else if (is_space(b)) begin
      end else if (b == CH_AT) begin
        mode = MD_TAG; tstart = pos; tlen = 1;
      end else if (b == CH_COLON) emit(K_COLON, pos, 1);
      else if (b == CH_PIPE) emit(K_PIPE, pos, 1);
      else if (b == CH_LANGLE) emit(K_LANGLE, pos, 1);
      else if (b == CH_RANGLE) emit(K_RANGLE, pos, 1);
      else begin
        mode = MD_LIT; tstart = pos; cand = match_kw(10'h3FF, 0, b); tlen = 1;
      end
    endfunction

    function void word_byte(logic [7:0] b, longint unsigned pos);
      logic [4:0] k;
      if (!(is_space(b) || b == CH_LANGLE || b == CH_RANGLE || b == CH_COLON)) begin
        cand = match_kw(cand, tlen, b);
        tlen = sat(tlen, 1);
        return;
      end
      k = word_kind();
      if (k == K_SCENARIO && b == CH_SPACE) begin
        mode = MD_OUT; omatch = 1; scen_start = tstart;
        return;
      end
      emit(k, tstart, tlen);
      start_byte(b, pos);
    endfunction

    // outline mismatch: Scenario goes out, the matched tail restarts as a literal
    function void drop_outline();
      emit(K_SCENARIO, scen_start, 8);
      mode = MD_IDLE;
      if (omatch >= 2) begin
        mode = MD_LIT; tstart = sat(scen_start, 9); tlen = omatch - 1; cand = '0;
      end
      omatch = 0;
    endfunction

    function void note_input(logic [7:0] b, logic eos);
      longint unsigned pos;
      pos = bpos;
      run.delete();
      if (eos) begin
        if (mode == MD_TAG) emit(K_TAG, tstart, tlen);
        else if (mode == MD_LIT) emit(word_kind(), tstart, tlen);
        else if (mode == MD_OUT) begin
          drop_outline();
          if (mode == MD_LIT) emit(K_LITERAL, tstart, tlen);
        end
        emit(K_END, bpos, 0);
        clear_state();
      end else begin
        bpos = sat(bpos, 1);
        case (mode)
          MD_TAG: begin
            if (is_space(b)) begin
              emit(K_TAG, tstart, tlen);
              start_byte(b, pos);
            end else tlen = sat(tlen, 1);
          end
          MD_LIT: word_byte(b, pos);
          MD_OUT: begin
            if (omatch >= 8) begin
              emit(K_OUTLINE, scen_start, 16);
              omatch = 0;
              start_byte(b, pos);
            end else if (tail[omatch] == b) omatch++;
            else begin
              drop_outline();
              if (mode == MD_LIT) word_byte(b, pos);
              else start_byte(b, pos);
            end
          end
          default: start_byte(b, pos);
        endcase
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) tokens_due = {tokens_due, run[i]};
    endfunction

    function void set_first_line(logic [23:0] v);
      fline = v;
      if (bpos == 0) lcount = v;
    endfunction

    function void check_result(logic [4:0] kind, logic [23:0] line, logic [31:0] st,
                               logic [31:0] ln, logic last);
      token_rec_t e;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected token kind=%0d start=%0d", kind, st);
        return;
      end
      e = tokens_due.pop_front();
      if (kind !== e.kind || line !== e.line || st !== e.start || ln !== e.len ||
          last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: token exp kind=%0d line=%0d start=%0d len=%0d last=%0b, got kind=%0d line=%0d start=%0d len=%0d last=%0b",
                   e.kind, e.line, e.start, e.len, e.last, kind, line, st, ln, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = '0;
  logic        in_end_of_source = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_token_kind;
  logic [23:0] out_line_number;
  logic [31:0] out_start_offset;
  logic [31:0] out_lexeme_length;
  logic        out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gherkin_token_lexer_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  token_scoreboard tokens = new();
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  localparam int CYCLE_LIMIT = 200000;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid && out_ready)
      tokens.check_result(out_token_kind, out_line_number, out_start_offset,
                          out_lexeme_length, out_last_of_run);
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_char_code <= b;
    in_end_of_source <= eos;
    do @(posedge clk); while (!in_ready);
    tokens.note_input(b, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic close_source();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold the sender until every token is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens.tokens_due.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_line(input logic [23:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_FIRST_LINE[0+:1], 2'b00};
    cfg_pwdata <= {8'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tokens.set_first_line(v);
  endtask

  task automatic random_chunk();
    string words[10];
    string w;
    int sel;
    words = '{"Feature", "Background", "Scenario", "ScenarioOutline", "Examples",
              "Given", "When", "Then", "And", "But"};
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2, 3: send_text({words[$urandom_range(0, 9)], " "});
      4, 5: begin
        send_text("Scenario Outline");
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      6: begin
        w = " Outline";
        send_text("Scenario");
        send_text(w.substr(0, $urandom_range(0, 7)));
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      7: begin
        send_item(CH_AT, 1'b0);
        repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(33, 126)), 1'b0);
        send_item(CH_SPACE, 1'b0);
      end
      8, 9: begin
        w = ":|<>";
        send_item(w[$urandom_range(0, 3)], 1'b0);
      end
      10, 11: send_item(8'($urandom_range(0, 255)), 1'b0);
      12: send_item(8'($urandom_range(9, 13)), 1'b0);
      13, 14: send_item(CH_NL, 1'b0);
      15: send_text({words[$urandom_range(0, 9)], ":"});
      16: send_item(CH_SPACE, 1'b0);
      17: if ($urandom_range(0, 2) == 0) close_source();
      default: repeat ($urandom_range(1, 5)) send_item(8'($urandom_range(97, 122)), 1'b0);
    endcase
  endtask

  task automatic random_phase(input int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) random_chunk();
    close_source();
    drain();
  endtask

  initial begin
    tokens.init();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, punctuation, outline merge and both mismatch forms
    send_text("@t Feature:|<>");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_NL, 1'b0);
    send_text("Scenario Outline x");
    send_text("Scenario Ou\tScenario Outline");
    close_source();
    send_text("Scenario Other Given\vBut");
    close_source();
    drain();

    write_first_line(24'd0);
    random_phase(40);
    write_first_line(LINE_MAX);
    send_text("\n\nWhen\n");
    random_phase(35);
    write_first_line(24'($urandom));
    send_text("Then x");
    drain();
    // written mid-source: takes effect only after the next close
    write_first_line(24'($urandom_range(2, 1000)));
    random_phase(40);

    drain();
    if (tokens.errors == 0 && tokens.tokens_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/gtl_pkg.sv
hdl/gtl_front.sv
hdl/gtl_back.sv
hdl/gherkin_token_lexer_unit.sv
test/tb_gherkin_token_lexer_unit.sv
